// File: rtl/line_substring_filter_macros.svh
// ----------------------------------------------------------------------------
// line substring filter assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_FILTER_MACROS_SVH
`define LINE_SUBSTRING_FILTER_MACROS_SVH

// same-cycle implication
`define LSF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// shared constants, types and helpers for the line substring filter
// ----------------------------------------------------------------------------
package lsf_pkg;

	localparam int MAX_PATTERN   = 16;
	localparam int COUNTER_WIDTH = 32;
	localparam int REG_BYTES     = 16;
	localparam int PAT_W         = MAX_PATTERN * 8;
	localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
	localparam int OUT_W         = 32;
	localparam int CFG_W         = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int LENREG_W      = 5;

	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY = 3'd5;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_EOF  = 1'b1;
	localparam logic RES_LINE  = 1'b0;
	localparam logic RES_TOTAL = 1'b1;

	localparam logic [7:0] NEWLINE = 8'd10;
	localparam logic [7:0] UPPER_A = 8'd65;
	localparam logic [7:0] UPPER_Z = 8'd90;
	localparam logic [7:0] FOLD_OFFSET = 8'd32;

	// compare settings handed to every cell
	typedef struct packed {
		logic [PAT_W-1:0] pattern;
		logic [LEN_W-1:0] len;
		logic             fold;
	} lsf_cfg_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
		if (en && c >= UPPER_A && c <= UPPER_Z) begin
			return c + FOLD_OFFSET;
		end
		return c;
	endfunction

endpackage

// File: rtl/lsf_cell.sv
// ----------------------------------------------------------------------------
// lsf_cell
// one window position: compares its incoming byte against the pattern byte
// that lines up with it, then holds that byte for the next cell
// ----------------------------------------------------------------------------
module lsf_cell (
	input  logic                     clk,
	input  logic                     shift,
	input  logic [7:0]               byte_in,
	input  logic [lsf_pkg::LEN_W-1:0] idx,
	input  lsf_pkg::lsf_cfg_t        cfg,
	output logic [7:0]               byte_q,
	output logic                     ok
);

	logic                      active;
	logic [lsf_pkg::LEN_W-1:0] sel;
	logic [7:0]                pat_byte;

	// cell k checks pattern byte len-1-k
	assign active = idx < cfg.len;
	assign sel    = cfg.len - idx - lsf_pkg::LEN_W'(1);

	always_comb begin
		pat_byte = '0;
		for (int j = 0; j < lsf_pkg::MAX_PATTERN; j++) begin
			if (lsf_pkg::LEN_W'(j) == sel) begin
				pat_byte = cfg.pattern[j*8 +: 8];
			end
		end
	end

	assign ok = !active ||
		(lsf_pkg::fold_byte(pat_byte, cfg.fold) == lsf_pkg::fold_byte(byte_in, cfg.fold));

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

// File: rtl/lsf_window.sv
// ----------------------------------------------------------------------------
// lsf_window
// row of compare cells over the most recent bytes of the line, with the
// count of valid bytes that gates a hit
// ----------------------------------------------------------------------------
module lsf_window (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic              clear,
	input  logic [7:0]        byte_in,
	input  lsf_pkg::lsf_cfg_t cfg,
	output logic              hit
);

	localparam logic [lsf_pkg::LEN_W-1:0] FILL_MAX = lsf_pkg::LEN_W'(lsf_pkg::MAX_PATTERN - 1);

	logic [7:0]                        chain [0:lsf_pkg::MAX_PATTERN];
	logic [lsf_pkg::MAX_PATTERN-1:0]   ok;
	logic [lsf_pkg::LEN_W-1:0]         fill_q;
	logic [lsf_pkg::LEN_W:0]           fill_next;
	logic                              enough;

	assign chain[0] = byte_in;

	for (genvar k = 0; k < lsf_pkg::MAX_PATTERN; k++) begin : g_cell
		lsf_cell u_cell (
			.clk     (clk),
			.shift   (shift),
			.byte_in (chain[k]),
			.idx     (lsf_pkg::LEN_W'(k)),
			.cfg     (cfg),
			.byte_q  (chain[k+1]),
			.ok      (ok[k])
		);
	end

	// stored bytes are only trusted once the line has held enough of them
	assign fill_next = {1'b0, fill_q} + (lsf_pkg::LEN_W+1)'(1);
	assign enough    = fill_next >= {1'b0, cfg.len};
	assign hit       = (cfg.len != '0) && enough && (&ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clear) begin
			fill_q <= '0;
		end else if (shift && fill_q < FILL_MAX) begin
			fill_q <= fill_next[lsf_pkg::LEN_W-1:0];
		end
	end

endmodule

// File: rtl/line_substring_filter.sv
// ----------------------------------------------------------------------------
// line_substring_filter
// fixed-string line filter over a byte stream
// ----------------------------------------------------------------------------
// A file arrives on the s_ channel as text items (tuser low, byte in tdata)
// closed by one end-of-file item (tuser high). Byte 10 ends a line; a last
// line with no newline still counts. A line is accepted when it holds the
// pattern (optionally case folded), flipped by invert_match.
// Normal mode: each accepted line gives one item on m_ with its line number,
// in the cycle after the item that closes it. Count mode: the end-of-file item
// gives the number of accepted lines. Line number and total restart at end
// of file and saturate.
// Throughput is one item per cycle while s_tready is high: the row of compare
// cells checks the whole window against the incoming byte in the cycle it
// arrives. Results pass through the output register. When the receiver stalls
// with a result held, s_tready drops until that result is taken; an item can
// enter in the same cycle the held result leaves.
// Reset clears the configuration, line state, counters (line 1) and output valid flag.
// Configuration is to be written on the cfg_ port while the stream is idle (unchecked).
// ----------------------------------------------------------------------------
module line_substring_filter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // data_byte
	input  logic                         s_tuser,   // kind
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [63:0]                  m_tdata,   // line_number, match_count
	output logic                         m_tuser,   // result_kind
	input  logic                         cfg_we,
	input  logic [lsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsf_pkg::CFG_W-1:0]     cfg_wdata
);

	`include "line_substring_filter_macros.svh"

	localparam int CW = lsf_pkg::COUNTER_WIDTH;

	logic [63:0]                   pat_low_q;
	logic [63:0]                   pat_high_q;
	logic [lsf_pkg::LENREG_W-1:0]  pat_len_q;
	logic                          fold_q;
	logic                          invert_q;
	logic                          count_only_q;

	logic                          line_open_q;
	logic                          found_q;
	logic [CW-1:0]                 cur_line_q;
	logic [CW-1:0]                 total_q;

	logic                          out_valid_q;
	logic                          out_kind_q;
	logic [63:0]                   out_data_q;

	lsf_pkg::lsf_cfg_t             cfg;
	logic [127:0]                  pat_regs;
	logic                          s_acc;
	logic                          is_eof;
	logic                          is_nl;
	logic                          shift;
	logic                          clear;
	logic                          hit;
	logic                          close;
	logic                          acc_line;
	logic                          emit_line;
	logic                          emit_total;
	logic [CW-1:0]                 line_inc;
	logic [CW-1:0]                 total_inc;
	logic [CW-1:0]                 total_out;

	assign pat_regs = {pat_high_q, pat_low_q};

	always_comb begin
		cfg = '0;
		for (int i = 0; i < lsf_pkg::MAX_PATTERN; i++) begin
			if (i < lsf_pkg::REG_BYTES) begin
				cfg.pattern[i*8 +: 8] = pat_regs[i*8 +: 8];
			end
		end
		if (int'(pat_len_q) > lsf_pkg::MAX_PATTERN) begin
			cfg.len = lsf_pkg::LEN_W'(lsf_pkg::MAX_PATTERN);
		end else begin
			cfg.len = lsf_pkg::LEN_W'(pat_len_q);
		end
		cfg.fold = fold_q;
	end

	assign s_tready = !out_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign is_eof   = s_tuser == lsf_pkg::KIND_EOF;
	assign is_nl    = s_tdata == lsf_pkg::NEWLINE;
	assign shift    = s_acc && !is_eof && !is_nl;
	assign clear    = s_acc && (is_eof || is_nl);

	lsf_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (shift),
		.clear   (clear),
		.byte_in (s_tdata),
		.cfg     (cfg),
		.hit     (hit)
	);

	// a line closes at newline, or at end of file if it holds any byte
	assign close      = s_acc && ((!is_eof && is_nl) || (is_eof && line_open_q));
	assign acc_line   = (found_q || cfg.len == '0) != invert_q;
	assign emit_line  = close && acc_line && !count_only_q;
	assign emit_total = s_acc && is_eof && count_only_q;

	assign line_inc  = (cur_line_q == lsf_pkg::CNT_MAX) ? cur_line_q : cur_line_q + CW'(1);
	assign total_inc = (total_q == lsf_pkg::CNT_MAX) ? total_q : total_q + CW'(1);
	assign total_out = (close && acc_line && count_only_q) ? total_inc : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q    <= '0;
			pat_high_q   <= '0;
			pat_len_q    <= '0;
			fold_q       <= 1'b0;
			invert_q     <= 1'b0;
			count_only_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				lsf_pkg::REG_PAT_LOW:    pat_low_q    <= cfg_wdata;
				lsf_pkg::REG_PAT_HIGH:   pat_high_q   <= cfg_wdata;
				lsf_pkg::REG_PAT_LEN:    pat_len_q    <= cfg_wdata[lsf_pkg::LENREG_W-1:0];
				lsf_pkg::REG_CASE_FOLD:  fold_q       <= cfg_wdata[0];
				lsf_pkg::REG_INVERT:     invert_q     <= cfg_wdata[0];
				lsf_pkg::REG_COUNT_ONLY: count_only_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_open_q <= 1'b0;
			found_q     <= 1'b0;
			cur_line_q  <= CW'(1);
			total_q     <= '0;
		end else if (s_acc) begin
			if (is_eof) begin
				line_open_q <= 1'b0;
				found_q     <= 1'b0;
				cur_line_q  <= CW'(1);
				total_q     <= '0;
			end else if (is_nl) begin
				line_open_q <= 1'b0;
				found_q     <= 1'b0;
				cur_line_q  <= line_inc;
				if (acc_line && count_only_q) begin
					total_q <= total_inc;
				end
			end else begin
				line_open_q <= 1'b1;
				found_q     <= found_q || hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_line || emit_total) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_line) begin
			out_kind_q <= lsf_pkg::RES_LINE;
			out_data_q <= {lsf_pkg::OUT_W'(0), lsf_pkg::OUT_W'(cur_line_q)};
		end else if (emit_total) begin
			out_kind_q <= lsf_pkg::RES_TOTAL;
			out_data_q <= {lsf_pkg::OUT_W'(total_out), lsf_pkg::OUT_W'(0)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

	`LSF_ASSERT_NOW(a_line_item_fields, m_tvalid && m_tuser == lsf_pkg::RES_LINE,
		m_tdata[63:32] == '0 && m_tdata[31:0] != '0, "line item with bad fields")
	`LSF_ASSERT_NEXT(a_eof_restart, s_acc && is_eof,
		cur_line_q == CW'(1) && total_q == '0 && !line_open_q, "counters not restarted")
	`LSF_ASSERT_NOW(a_found_in_open_line, found_q, line_open_q, "match outside open line")

endmodule
